/* rtl/core/wavhc_pkg.sv */
// Shared types, codes and constants for the WAV header check and downmix block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package wavhc_pkg;

  // Result item kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // Header verdict codes, in priority order after the short-header case.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_RIFF  = 3'd2,
    ST_NOT_PCM   = 3'd3,
    ST_NOT_16BIT = 3'd4
  } status_t;

  // Parser phases, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_STREAM  = 3'b010,
    PH_DISCARD = 3'b100
  } phase_t;

  // One result item as it travels from the parser to the output queue.
  typedef struct packed {
    kind_t        kind;
    status_t      status;
    logic [15:0]  channel_count;
    logic [31:0]  rate_hz;
    logic [15:0]  pcm_sample;
    logic         last;
  } res_t;

  // Header layout and the values the header must carry.
  localparam logic [5:0]  HDR_LAST_POS = 6'd43;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] BITS_16      = 16'd16;
  localparam logic [15:0] CH_STEREO    = 16'd2;

  // Characters of the "RIFF" tag by position.
  function automatic logic [7:0] riff_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h52;
      2'd1:    c = 8'h49;
      2'd2:    c = 8'h46;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

  // Characters of the "WAVE" tag by position.
  function automatic logic [7:0] wave_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h57;
      2'd1:    c = 8'h41;
      2'd2:    c = 8'h56;
      default: c = 8'h45;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/wavhc_parse.sv */
// Byte parser: header capture and checks, sample assembly and stereo downmix.
// Depends on wavhc_pkg. Produces at most one result per accepted byte.
`timescale 1ns / 1ps

module wavhc_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       data_byte,
  input  logic             end_of_file,
  output logic             res_valid,
  output wavhc_pkg::res_t  res
);

  wavhc_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        tag_ok_r, tag_ok_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [23:0] frame_r, frame_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic               go_idle;
  logic               done;
  logic [15:0]        sample;
  wavhc_pkg::status_t verdict;

  // Stereo downmix: each channel halved toward zero, then summed.
  logic signed [15:0] left_s, right_s;
  logic signed [16:0] left_adj, right_adj, left_half, right_half, mono;

  assign left_s    = $signed(frame_r[15:0]);
  assign right_s   = $signed({data_byte, frame_r[23:16]});
  assign left_adj  = $signed({left_s[15], left_s}) + $signed({16'd0, left_s[15]});
  assign right_adj = $signed({right_s[15], right_s}) + $signed({16'd0, right_s[15]});
  assign left_half  = left_adj >>> 1;
  assign right_half = right_adj >>> 1;
  assign mono       = left_half + right_half;

  // Verdict from the captured header fields, tag error first.
  always_comb begin
    if (!tag_ok_r) begin
      verdict = wavhc_pkg::ST_NOT_RIFF;
    end else if (fmt_r != wavhc_pkg::FMT_PCM) begin
      verdict = wavhc_pkg::ST_NOT_PCM;
    end else if (depth_r != wavhc_pkg::BITS_16) begin
      verdict = wavhc_pkg::ST_NOT_16BIT;
    end else begin
      verdict = wavhc_pkg::ST_OK;
    end
  end

  // Next state and result for one accepted byte.
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    tag_ok_nxt = tag_ok_r;
    fmt_nxt    = fmt_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    depth_nxt  = depth_r;
    frame_nxt  = frame_r;
    idx_nxt    = idx_r;
    go_idle    = 1'b0;
    done       = 1'b0;
    sample     = 16'd0;
    res_valid  = 1'b0;
    res        = '0;

    if (acc) begin
      unique case (phase_r)
        wavhc_pkg::PH_STREAM: begin
          if (chan_r == wavhc_pkg::CH_STEREO) begin
            if (idx_r == 2'd3) begin
              sample    = mono[15:0];
              done      = 1'b1;
              idx_nxt   = 2'd0;
              frame_nxt = 24'd0;
            end else begin
              case (idx_r)
                2'd0:    frame_nxt[7:0]   = data_byte;
                2'd1:    frame_nxt[15:8]  = data_byte;
                default: frame_nxt[23:16] = data_byte;
              endcase
              idx_nxt = idx_r + 2'd1;
            end
          end else if (chan_r != 16'd0) begin
            if (idx_r != 2'd0) begin
              sample    = {data_byte, frame_r[7:0]};
              done      = 1'b1;
              idx_nxt   = 2'd0;
              frame_nxt = 24'd0;
            end else begin
              frame_nxt = {16'd0, data_byte};
              idx_nxt   = 2'd1;
            end
          end
          if (done) begin
            res_valid      = 1'b1;
            res.kind       = wavhc_pkg::KIND_SAMPLE;
            res.pcm_sample = sample;
            res.last       = end_of_file;
            go_idle        = end_of_file;
          end else if (end_of_file) begin
            res_valid = 1'b1;
            res.kind  = wavhc_pkg::KIND_END;
            res.last  = 1'b1;
            go_idle   = 1'b1;
          end
        end

        wavhc_pkg::PH_DISCARD: begin
          if (end_of_file) begin
            res_valid = 1'b1;
            res.kind  = wavhc_pkg::KIND_END;
            res.last  = 1'b1;
            go_idle   = 1'b1;
          end
        end

        default: begin
          // Tag checks and field capture by header position.
          if (pos_r < 6'd4 && data_byte != wavhc_pkg::riff_char(pos_r[1:0])) begin
            tag_ok_nxt = 1'b0;
          end
          if (pos_r >= 6'd8 && pos_r < 6'd12 &&
              data_byte != wavhc_pkg::wave_char(pos_r[1:0])) begin
            tag_ok_nxt = 1'b0;
          end
          case (pos_r)
            6'd20:   fmt_nxt[7:0]    = data_byte;
            6'd21:   fmt_nxt[15:8]   = data_byte;
            6'd22:   chan_nxt[7:0]   = data_byte;
            6'd23:   chan_nxt[15:8]  = data_byte;
            6'd24:   rate_nxt[7:0]   = data_byte;
            6'd25:   rate_nxt[15:8]  = data_byte;
            6'd26:   rate_nxt[23:16] = data_byte;
            6'd27:   rate_nxt[31:24] = data_byte;
            6'd34:   depth_nxt[7:0]  = data_byte;
            6'd35:   depth_nxt[15:8] = data_byte;
            default: ;
          endcase

          if (pos_r != wavhc_pkg::HDR_LAST_POS) begin
            pos_nxt = pos_r + 6'd1;
            if (end_of_file) begin
              res_valid  = 1'b1;
              res.kind   = wavhc_pkg::KIND_VERDICT;
              res.status = wavhc_pkg::ST_SHORT;
              res.last   = 1'b1;
              go_idle    = 1'b1;
            end
          end else begin
            res_valid         = 1'b1;
            res.kind          = wavhc_pkg::KIND_VERDICT;
            res.status        = verdict;
            res.channel_count = chan_r;
            res.rate_hz       = rate_r;
            res.last          = end_of_file;
            go_idle           = end_of_file;
            pos_nxt           = 6'd0;
            frame_nxt         = 24'd0;
            idx_nxt           = 2'd0;
            phase_nxt         = (verdict == wavhc_pkg::ST_OK) ? wavhc_pkg::PH_STREAM
                                                              : wavhc_pkg::PH_DISCARD;
          end
        end
      endcase

      // The end flag returns everything to the after-reset state.
      if (go_idle) begin
        phase_nxt  = wavhc_pkg::PH_HEADER;
        pos_nxt    = 6'd0;
        tag_ok_nxt = 1'b1;
        fmt_nxt    = 16'd0;
        chan_nxt   = 16'd0;
        rate_nxt   = 32'd0;
        depth_nxt  = 16'd0;
        frame_nxt  = 24'd0;
        idx_nxt    = 2'd0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wavhc_pkg::PH_HEADER;
      pos_r    <= 6'd0;
      tag_ok_r <= 1'b1;
      fmt_r    <= 16'd0;
      chan_r   <= 16'd0;
      rate_r   <= 32'd0;
      depth_r  <= 16'd0;
      frame_r  <= 24'd0;
      idx_r    <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      tag_ok_r <= tag_ok_nxt;
      fmt_r    <= fmt_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      depth_r  <= depth_nxt;
      frame_r  <= frame_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

/* rtl/core/wavhc_outq.sv */
// Two-entry result register with skid entry, decoupling parser from the output.
// Depends on wavhc_pkg for the result item type.
`timescale 1ns / 1ps

module wavhc_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wavhc_pkg::res_t  din,
  output logic             full,
  output logic             dout_valid,
  input  logic             dout_stall,
  output wavhc_pkg::res_t  dout
);

  wavhc_pkg::res_t head_r, head_nxt;
  wavhc_pkg::res_t skid_r, skid_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            pop;

  assign full       = (cnt_r == 2'd2);
  assign dout_valid = (cnt_r != 2'd0);
  assign dout       = head_r;
  assign pop        = dout_valid && !dout_stall;

  // Head takes the skid entry or the new item; skid only fills when head stays.
  always_comb begin
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (cnt_r == 2'd0) begin
      if (push) begin
        head_nxt = din;
      end
    end else if (pop) begin
      if (cnt_r == 2'd2) begin
        head_nxt = skid_r;
      end else if (push) begin
        head_nxt = din;
      end
    end else if (push && cnt_r == 2'd1) begin
      skid_nxt = din;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Occupancy is control state; the entries themselves need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

/* rtl/core/wav_header_check_and_downmix.sv */
// WAV header check and stereo-to-mono downmix, one byte per transfer.
// A result is registered in the output queue before it is presented on the out_ channel.
// Throughput: one byte per cycle when not stalled; the parser updates in one pass per transfer.
// A two-entry output register keeps input transfers going while a result waits.
// Reset (rst_n low, synchronous) returns the parser to awaiting a header and empties the output.
`timescale 1ns / 1ps

module wav_header_check_and_downmix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_item_kind,
  output logic [2:0]  out_status,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_rate_hz,
  output logic signed [15:0] out_pcm_sample,
  output logic        out_last
);

  logic            in_xfer;
  logic            res_valid;
  logic            q_full;
  wavhc_pkg::res_t res;
  wavhc_pkg::res_t q_out;

  // A byte transfers whenever the output queue has room.
  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  wavhc_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_xfer),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .res_valid   (res_valid),
    .res         (res)
  );

  wavhc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .din        (res),
    .full       (q_full),
    .dout_valid (out_valid),
    .dout_stall (out_stall),
    .dout       (q_out)
  );

  // Result fields onto their ports.
  assign out_item_kind     = q_out.kind;
  assign out_status        = q_out.status;
  assign out_channel_count = q_out.channel_count;
  assign out_rate_hz       = q_out.rate_hz;
  assign out_pcm_sample    = $signed(q_out.pcm_sample);
  assign out_last          = q_out.last;

endmodule

/* tb/wav_header_check_and_downmix_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wav_header_check_and_downmix: streams directed and random WAV
// files byte by byte, predicts every verdict, sample and end item, and checks each output.
// Depends on wavhc_pkg and the wav_header_check_and_downmix RTL.

module wav_header_check_and_downmix_tb;

  localparam int HDR_BYTES      = 44;
  localparam int RANDOM_BYTES   = 610;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int NUM_DIRECTED   = 20;

  localparam logic [31:0] RIFF_TAG     = "RIFF";
  localparam logic [31:0] WAVE_TAG     = "WAVE";
  localparam logic [7:0]  NO_TAG_FAULT = 8'hFF;

  // Short names for the header values the table uses most.
  localparam logic [15:0] PCM_FMT = wavhc_pkg::FMT_PCM;
  localparam logic [15:0] STEREO  = wavhc_pkg::CH_STEREO;
  localparam logic [15:0] BITS16  = wavhc_pkg::BITS_16;

  // Payload bytes that give the sample extremes, both as mono samples and as stereo frames.
  localparam logic [7:0] EXTREME_DATA [8] = '{
    8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h80, 8'hFF, 8'hFF
  };

  // Idle and stall percentages for each traffic phase.
  localparam int SEND_IDLE_PCT [4] = '{0, 57, 0, 32};
  localparam int STALL_PCT     [4] = '{0, 0, 57, 32};

  // One file to stream: header fields, an optional tag fault, its length and the verdict.
  typedef struct packed {
    logic [7:0]         bad_tag_pos;
    logic [7:0]         tag_xor;
    logic [15:0]        fmt;
    logic [15:0]        chans;
    logic [15:0]        bits;
    logic [31:0]        rate;
    logic [15:0]        file_len;
    logic               noise;
    wavhc_pkg::status_t verdict;
  } wav_file_t;

  localparam wav_file_t DIRECTED_FILES [NUM_DIRECTED] = '{
    // End on the first byte and on the last byte before the header completes.
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd44100, 16'd1, 1'b0,
      wavhc_pkg::ST_SHORT},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd44100, 16'd43, 1'b0,
      wavhc_pkg::ST_SHORT},
    // End on the final header byte, then stereo with full and partial trailing frames.
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd44100, 16'd44, 1'b0,
      wavhc_pkg::ST_OK},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd48000, 16'd60, 1'b0,
      wavhc_pkg::ST_OK},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd48000, 16'd54, 1'b0,
      wavhc_pkg::ST_OK},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd48000, 16'd51, 1'b0,
      wavhc_pkg::ST_OK},
    // Mono pass-through with an odd and an even payload.
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, 16'd1, BITS16, 32'd8000, 16'd53, 1'b0,
      wavhc_pkg::ST_OK},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, 16'd1, BITS16, 32'd0, 16'd52, 1'b0,
      wavhc_pkg::ST_OK},
    // Zero channels, the largest channel count and rate, and a multichannel file.
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, 16'd0, BITS16, 32'd16000, 16'd50, 1'b0,
      wavhc_pkg::ST_OK},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, 16'hFFFF, BITS16, 32'hFFFFFFFF, 16'd50, 1'b0,
      wavhc_pkg::ST_OK},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, 16'd6, BITS16, 32'd96000, 16'd48, 1'b0,
      wavhc_pkg::ST_OK},
    // A tag fault outranks the format and bit-depth faults.
    '{8'd0, 8'hFF, 16'd3, STEREO, 16'd8, 32'd44100, 16'd50, 1'b0,
      wavhc_pkg::ST_NOT_RIFF},
    '{8'd11, 8'h01, PCM_FMT, STEREO, BITS16, 32'd44100, 16'd49, 1'b0,
      wavhc_pkg::ST_NOT_RIFF},
    // A format fault outranks the bit-depth fault.
    '{NO_TAG_FAULT, 8'h00, 16'd3, STEREO, 16'd8, 32'd44100, 16'd50, 1'b0,
      wavhc_pkg::ST_NOT_PCM},
    '{NO_TAG_FAULT, 8'h00, 16'hFFFF, 16'd1, BITS16, 32'd11025, 16'd44, 1'b0,
      wavhc_pkg::ST_NOT_PCM},
    '{NO_TAG_FAULT, 8'h00, 16'h0101, 16'd1, BITS16, 32'd11025, 16'd46, 1'b0,
      wavhc_pkg::ST_NOT_PCM},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, 16'd24, 32'd44100, 16'd48, 1'b0,
      wavhc_pkg::ST_NOT_16BIT},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, 16'h1010, 32'd44100, 16'd44, 1'b0,
      wavhc_pkg::ST_NOT_16BIT},
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, 16'd1, 16'd0, 32'd44100, 16'd45, 1'b0,
      wavhc_pkg::ST_NOT_16BIT},
    // A good file right after the rejected ones.
    '{NO_TAG_FAULT, 8'h00, PCM_FMT, STEREO, BITS16, 32'd22050, 16'd56, 1'b0,
      wavhc_pkg::ST_OK}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_item_kind;
  logic [2:0]  out_status;
  logic [15:0] out_channel_count;
  logic [31:0] out_rate_hz;
  logic signed [15:0] out_pcm_sample;
  logic        out_last;

  // Predicted result items still to arrive, oldest first.
  wavhc_pkg::res_t wav_items_due[$];
  wavhc_pkg::res_t want;
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  // Directed files carry their verdict code typed in from the table.
  bit                 typed_verdict_on = 1'b0;
  wavhc_pkg::status_t typed_verdict = wavhc_pkg::ST_OK;

  // Parser state as the predictor tracks it.
  wavhc_pkg::phase_t pred_phase;
  logic [5:0]  pred_hdr_pos;
  logic        pred_tags_ok;
  logic [15:0] pred_fmt;
  logic [15:0] pred_chans;
  logic [31:0] pred_rate;
  logic [15:0] pred_bits;
  logic [23:0] pred_frame;
  logic [1:0]  pred_frame_idx;

  wav_header_check_and_downmix i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_status        (out_status),
    .out_channel_count (out_channel_count),
    .out_rate_hz       (out_rate_hz),
    .out_pcm_sample    (out_pcm_sample),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  // Character k of a four-character tag, first character at k = 0.
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input int k);
    return tag[8*(3-k) +: 8];
  endfunction

  // Back to awaiting a header, as after reset or any end byte.
  task automatic clear_parser_model();
    pred_phase     = wavhc_pkg::PH_HEADER;
    pred_hdr_pos   = '0;
    pred_tags_ok   = 1'b1;
    pred_fmt       = '0;
    pred_chans     = '0;
    pred_rate      = '0;
    pred_bits      = '0;
    pred_frame     = '0;
    pred_frame_idx = '0;
  endtask

  // Advance the parser by one byte and return the result item it causes, if any.
  task automatic predict_wav_step(input logic [7:0] b, input logic eof,
                                  output bit produced, output wavhc_pkg::res_t o);
    logic [5:0]         p;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [16:0] mono;
    wavhc_pkg::status_t st;
    o = '0;
    produced = 1'b0;
    p = pred_hdr_pos;
    case (pred_phase)
      wavhc_pkg::PH_STREAM: begin
        if (pred_chans == wavhc_pkg::CH_STEREO) begin
          if (pred_frame_idx == 2'd3) begin
            left  = pred_frame[15:0];
            right = {b, pred_frame[23:16]};
            // Each half truncates toward zero before the sum.
            mono  = 17'(left / 2 + right / 2);
            o.kind = wavhc_pkg::KIND_SAMPLE;
            o.pcm_sample = mono[15:0];
            produced = 1'b1;
            pred_frame = '0;
            pred_frame_idx = '0;
          end else begin
            pred_frame[pred_frame_idx*8 +: 8] = b;
            pred_frame_idx = pred_frame_idx + 2'd1;
          end
        end else if (pred_chans != 16'd0) begin
          if (pred_frame_idx != 2'd0) begin
            o.kind = wavhc_pkg::KIND_SAMPLE;
            o.pcm_sample = {b, pred_frame[7:0]};
            produced = 1'b1;
            pred_frame = '0;
            pred_frame_idx = '0;
          end else begin
            pred_frame = {16'd0, b};
            pred_frame_idx = 2'd1;
          end
        end
        // A partial frame at the end is dropped in favor of an end item.
        if (produced) begin
          o.last = eof;
        end else if (eof) begin
          o.kind = wavhc_pkg::KIND_END;
          o.last = 1'b1;
          produced = 1'b1;
        end
        if (eof) clear_parser_model();
      end
      wavhc_pkg::PH_DISCARD: begin
        if (eof) begin
          o.kind = wavhc_pkg::KIND_END;
          o.last = 1'b1;
          produced = 1'b1;
          clear_parser_model();
        end
      end
      default: begin
        if (p < 6'd4) begin
          if (b != tag_byte(RIFF_TAG, int'(p))) pred_tags_ok = 1'b0;
        end
        if (p >= 6'd8 && p < 6'd12) begin
          if (b != tag_byte(WAVE_TAG, int'(p) - 8)) pred_tags_ok = 1'b0;
        end
        if (p == 6'd20) pred_fmt[7:0] = b;
        if (p == 6'd21) pred_fmt[15:8] = b;
        if (p == 6'd22) pred_chans[7:0] = b;
        if (p == 6'd23) pred_chans[15:8] = b;
        if (p >= 6'd24 && p < 6'd28) pred_rate[(p-24)*8 +: 8] = b;
        if (p == 6'd34) pred_bits[7:0] = b;
        if (p == 6'd35) pred_bits[15:8] = b;
        if (p != wavhc_pkg::HDR_LAST_POS) begin
          pred_hdr_pos = p + 6'd1;
          if (eof) begin
            o.kind = wavhc_pkg::KIND_VERDICT;
            o.status = wavhc_pkg::ST_SHORT;
            o.last = 1'b1;
            produced = 1'b1;
            clear_parser_model();
          end
        end else begin
          if (!pred_tags_ok) st = wavhc_pkg::ST_NOT_RIFF;
          else if (pred_fmt != wavhc_pkg::FMT_PCM) st = wavhc_pkg::ST_NOT_PCM;
          else if (pred_bits != wavhc_pkg::BITS_16) st = wavhc_pkg::ST_NOT_16BIT;
          else st = wavhc_pkg::ST_OK;
          o.kind = wavhc_pkg::KIND_VERDICT;
          o.status = st;
          o.channel_count = pred_chans;
          o.rate_hz = pred_rate;
          o.last = eof;
          produced = 1'b1;
          if (eof) begin
            clear_parser_model();
          end else begin
            pred_hdr_pos = '0;
            pred_phase = (st == wavhc_pkg::ST_OK) ? wavhc_pkg::PH_STREAM
                                                  : wavhc_pkg::PH_DISCARD;
            pred_frame = '0;
            pred_frame_idx = '0;
          end
        end
      end
    endcase
  endtask

  // Offer one byte, wait for its transfer, and record what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    bit              produced;
    wavhc_pkg::res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_wav_step(b, eof, produced, r);
    if (produced) begin
      if (typed_verdict_on && r.kind == wavhc_pkg::KIND_VERDICT) r.status = typed_verdict;
      wav_items_due = {wav_items_due, r};
    end
  endtask

  // Stream one file, flagging end of file on its last byte.
  task automatic send_file(input wav_file_t f, input bit extreme_data);
    logic [7:0] b;
    for (int i = 0; i < int'(f.file_len); i++) begin
      b = 8'($urandom);
      if (!f.noise) begin
        case (i)
          0, 1, 2, 3:     b = tag_byte(RIFF_TAG, i);
          8, 9, 10, 11:   b = tag_byte(WAVE_TAG, i - 8);
          20:             b = f.fmt[7:0];
          21:             b = f.fmt[15:8];
          22:             b = f.chans[7:0];
          23:             b = f.chans[15:8];
          24, 25, 26, 27: b = f.rate[8*(i-24) +: 8];
          34:             b = f.bits[7:0];
          35:             b = f.bits[15:8];
          default: begin
            if (i >= HDR_BYTES && extreme_data) b = EXTREME_DATA[(i - HDR_BYTES) % 8];
          end
        endcase
        if (i == int'(f.bad_tag_pos)) b = b ^ f.tag_xor;
      end
      send_byte(b, i == int'(f.file_len) - 1);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Result side: random stall, compare each transfer, and watch for a hang.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (wav_items_due.size() == 0) begin
        $error("result transfer with nothing expected: kind %0h", out_item_kind);
        mismatch_count++;
      end else begin
        want = wav_items_due.pop_front();
        check_field("item_kind", 32'(want.kind), 32'(out_item_kind));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("channel_count", 32'(want.channel_count), 32'(out_channel_count));
        check_field("rate_hz", want.rate_hz, out_rate_hz);
        check_field("pcm_sample", 32'(want.pcm_sample), 32'(out_pcm_sample[15:0]));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus: directed files, a drain, then random files across the traffic phases.
  initial begin
    wav_file_t f;
    int        roll;
    int        slot;
    int        phase_sel;
    int        file_idx;
    int        random_bytes;
    clear_parser_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files run with no idling on either side.
    typed_verdict_on = 1'b1;
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      typed_verdict = DIRECTED_FILES[n].verdict;
      send_file(DIRECTED_FILES[n], 1'b1);
    end
    typed_verdict_on = 1'b0;

    // Hold the sender until every expected result has come back.
    in_valid <= 1'b0;
    @(posedge clk);
    while (wav_items_due.size() != 0) @(posedge clk);

    random_bytes = 0;
    file_idx = 0;
    while (random_bytes < RANDOM_BYTES) begin
      // The random bytes are split evenly over the four traffic phases.
      phase_sel     = (random_bytes * 4) / RANDOM_BYTES;
      send_idle_pct = SEND_IDLE_PCT[phase_sel];
      stall_pct     = STALL_PCT[phase_sel];

      // Mostly well-formed files; the channel mix favors stereo and mono.
      f = '0;
      f.bad_tag_pos = NO_TAG_FAULT;
      f.tag_xor  = 8'($urandom_range(1, 255));
      f.fmt      = wavhc_pkg::FMT_PCM;
      f.bits     = wavhc_pkg::BITS_16;
      f.rate     = $urandom;
      f.file_len = 16'(HDR_BYTES + $urandom_range(0, 64));
      roll = $urandom_range(99);
      if (roll < 45) f.chans = wavhc_pkg::CH_STEREO;
      else if (roll < 75) f.chans = 16'd1;
      else if (roll < 88) f.chans = 16'($urandom_range(0, 8));
      else f.chans = 16'($urandom);

      // A minority of broken headers, short files and pure noise.
      roll = $urandom_range(99);
      if (roll < 6) begin
        slot = $urandom_range(0, 7);
        f.bad_tag_pos = 8'((slot < 4) ? slot : slot + 4);
      end else if (roll < 10) begin
        f.fmt = 16'($urandom);
      end else if (roll < 14) begin
        f.bits = 16'($urandom);
      end else if (roll < 18) begin
        f.file_len = 16'($urandom_range(1, HDR_BYTES - 1));
      end else if (roll < 21) begin
        f.noise = 1'b1;
        f.file_len = 16'($urandom_range(1, 60));
      end

      send_file(f, 1'b0);
      random_bytes += int'(f.file_len);
      file_idx++;
    end

    in_valid <= 1'b0;
    while (wav_items_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
